>>> design/rqlh_pkg.sv
// Shared types, field widths and helper functions for the run queue latency histogram unit.
// Depends on nothing; the top level and the divider import it.
package rqlh_pkg;

    // Event kinds carried on the input tuser.
    typedef enum logic [1:0] {
        ACT_WAKE   = 2'd0,
        ACT_SWITCH = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    localparam int ACTION_W  = 2;
    localparam int TASK_ID_W = 15;
    localparam int TIME_W    = 64;
    localparam int BIDX_W    = 5;
    localparam int LAT_W     = 55;
    localparam int BKT_W     = 5;
    localparam int CNT_W     = 64;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 128;

    // Nanoseconds to microseconds.
    localparam logic [9:0] NS_PER_US = 10'd1000;
    localparam int REM_W             = 10;

    // The divide works on 16-bit chunks. The reciprocal ceil(2^36 / 1000) gives the
    // exact quotient of any partial dividend below 2^26.
    localparam int          DIV_CHUNK_W = 16;
    localparam int          DIV_RECIP_W = 27;
    localparam logic [26:0] DIV_RECIP   = 27'd68719477;
    localparam int          DIV_SHIFT   = 36;

    // Waits above 2^LOG_SPAN-1 all land in the top bucket.
    localparam int          LOG_SPAN       = 31;
    localparam logic [4:0]  MAX_LOG_BUCKET = 5'd31;

    // Number of significant bits of a 31-bit value.
    function automatic logic [4:0] rqlh_bitlen(input logic [LOG_SPAN-1:0] v);
        logic [4:0] len;
        len = 5'd0;
        for (int i = 0; i < LOG_SPAN; i++) begin
            if (v[i])
            begin
                len = 5'(i + 1);
            end
        end
        return len;
    endfunction

endpackage

>>> design/run_queue_latency_histogram_unit.sv
// Run queue latency histogram: top level with the sequencer, task table and bucket counters.
// Depends on rqlh_pkg, rqlh_ram and rqlh_div1000.
//
// Usage: one input transaction per event on the s_ group; s_tuser carries the
// event kind (wakeup, context switch, bucket read). Every input transaction
// produces exactly one output transaction on the m_ group. A wakeup stores the
// timestamp of a task; a switch looks up the incoming task, measures its wait
// in microseconds, counts it in a log2 bucket and optionally re-arms the
// outgoing task; a read returns one 64-bit bucket counter.
// Items are handled one at a time: the next input is taken only once the
// result of the last one has gone into the output register. A wakeup passes
// S_WAKE; a read or unused kind S_LOOK and S_CHECK; a switch adds S_PREV, and
// one that records a wait also the divide by 1000 and the read-modify-write of
// the counter RAM, which make it the longest case. s_tready is high when idle.
// After reset the task table is cleared one entry per cycle; s_tready stays
// low during that pass. The bucket counters are cleared at once by per-bucket
// valid flags. The output register holds a result while m_tready is low, and
// the next input is still accepted then; its result waits until the register
// is free.
module run_queue_latency_histogram_unit #(
    parameter int TASK_SLOTS = 32768,
    parameter int BUCKETS    = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // task_id[14:0], prev_task_id[29:15], preempted[30], now_ns[94:31],
    // bucket_index[99:95], zero fill[103:100]
    input  logic [rqlh_pkg::S_TDATA_W-1:0] s_tdata,
    // action[1:0]
    input  logic [rqlh_pkg::ACTION_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // latency_us[54:0], bucket[59:55], bucket_count[123:60], zero fill[127:124]
    output logic [rqlh_pkg::M_TDATA_W-1:0] m_tdata,
    // latency_recorded[0]
    output logic                           m_tuser
);
    import rqlh_pkg::*;

    localparam int AW    = $clog2(TASK_SLOTS);
    localparam int BW    = $clog2(BUCKETS);
    localparam int ENT_W = TIME_W + 1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WAKE,
        S_LOOK,
        S_CHECK,
        S_DIV,
        S_LOG,
        S_ENC,
        S_CRD,
        S_CWR,
        S_PREV,
        S_OUT
    } state_t;

    state_t              state_reg;
    logic [AW-1:0]       clr_reg;
    logic                m_tvalid_reg;
    logic [BUCKETS-1:0]  cvalid_reg;

    // Latched item.
    action_t             act_reg;
    logic [TASK_ID_W-1:0] task_reg;
    logic [TASK_ID_W-1:0] prev_reg;
    logic                pre_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [BIDX_W-1:0]   idx_reg;

    // Result under construction.
    logic                rec_reg;
    logic [LAT_W-1:0]    lat_reg;
    logic [BKT_W-1:0]    bkt5_reg;
    logic [BW-1:0]       bkt_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [LOG_SPAN-1:0] wm1_reg;
    logic                big_reg;
    logic                zero_reg;

    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    logic                accept;
    logic                out_free;
    logic                task_in;
    logic                task_ok;
    logic                prev_ok;
    logic                idx_ok;
    logic [AW-1:0]       task_addr;
    logic [AW-1:0]       prev_addr;
    logic [BW-1:0]       idx_addr;
    logic                hit;

    logic                t_we;
    logic [AW-1:0]       t_waddr;
    logic [ENT_W-1:0]    t_wdata;
    logic [ENT_W-1:0]    t_rdata;

    logic                c_we;
    logic [BW-1:0]       c_raddr;
    logic [CNT_W-1:0]    c_rdata;
    logic [CNT_W-1:0]    c_cur;

    logic                div_start;
    logic                div_done;
    logic [TIME_W-1:0]   div_quot;

    logic [BKT_W-1:0]    raw_bkt;
    logic [31:0]         sat_bkt;

    assign accept   = s_tvalid && (state_reg == S_IDLE);
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    assign task_in   = 32'(task_reg) < TASK_SLOTS;
    assign task_ok   = task_in && (task_reg != '0);
    assign prev_ok   = (32'(prev_reg) < TASK_SLOTS) && (prev_reg != '0);
    assign idx_ok    = 32'(idx_reg) < BUCKETS;
    assign task_addr = AW'(32'(task_reg));
    assign prev_addr = AW'(32'(prev_reg));
    assign idx_addr  = BW'(32'(idx_reg));

    // Each table entry holds a pending flag above the start time.
    assign hit = (act_reg == ACT_SWITCH) && task_in && t_rdata[TIME_W];

    always_comb
    begin
        t_we    = 1'b0;
        t_waddr = task_addr;
        t_wdata = {1'b1, now_reg};
        unique case (state_reg)
            S_CLEAR:
            begin
                t_we    = 1'b1;
                t_waddr = clr_reg;
                t_wdata = '0;
            end
            S_WAKE:
            begin
                t_we = task_ok;
            end
            S_CHECK:
            begin
                t_we    = hit;
                t_wdata = {1'b0, now_reg};
            end
            S_PREV:
            begin
                t_we    = pre_reg && prev_ok;
                t_waddr = prev_addr;
            end
            default:
            begin
                t_we = 1'b0;
            end
        endcase
    end

    rqlh_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TASK_SLOTS)
    ) u_task_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (task_addr),
        .rdata (t_rdata)
    );

    // A bucket that was never written since reset reads as zero.
    assign c_cur   = cvalid_reg[bkt_reg] ? c_rdata : '0;
    assign c_we    = (state_reg == S_CWR);
    assign c_raddr = (state_reg == S_CRD) ? bkt_reg : idx_addr;

    rqlh_ram #(
        .WIDTH (CNT_W),
        .DEPTH (BUCKETS)
    ) u_count_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (bkt_reg),
        .wdata (c_cur + 1'b1),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    assign div_start = (state_reg == S_CHECK) && hit;

    rqlh_div1000 u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (now_reg - t_rdata[TIME_W-1:0]),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign raw_bkt = big_reg ? MAX_LOG_BUCKET :
                     (zero_reg ? '0 : rqlh_bitlen(wm1_reg));
    assign sat_bkt = (32'(raw_bkt) >= BUCKETS) ? 32'(BUCKETS - 1) : 32'(raw_bkt);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            cvalid_reg   <= '0;
        end
        else
        begin
            if (state_reg == S_OUT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(TASK_SLOTS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= (action_t'(s_tuser) == ACT_WAKE) ? S_WAKE : S_LOOK;
                    end
                end
                S_WAKE:  state_reg <= S_OUT;
                S_LOOK:  state_reg <= S_CHECK;
                S_CHECK:
                begin
                    if (act_reg == ACT_SWITCH)
                    begin
                        state_reg <= hit ? S_DIV : S_PREV;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_LOG;
                    end
                end
                S_LOG:   state_reg <= S_ENC;
                S_ENC:   state_reg <= S_CRD;
                S_CRD:   state_reg <= S_CWR;
                S_CWR:
                begin
                    cvalid_reg[bkt_reg] <= 1'b1;
                    state_reg           <= S_PREV;
                end
                S_PREV:  state_reg <= S_OUT;
                S_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= action_t'(s_tuser);
            task_reg <= s_tdata[14:0];
            prev_reg <= s_tdata[29:15];
            pre_reg  <= s_tdata[30];
            now_reg  <= s_tdata[94:31];
            idx_reg  <= s_tdata[99:95];
            rec_reg  <= 1'b0;
            lat_reg  <= '0;
            bkt5_reg <= '0;
            cnt_reg  <= '0;
        end
        if (state_reg == S_CHECK && act_reg == ACT_READ && idx_ok && cvalid_reg[idx_addr])
        begin
            cnt_reg <= c_rdata;
        end
        if (state_reg == S_DIV && div_done)
        begin
            lat_reg <= div_quot[LAT_W-1:0];
        end
        if (state_reg == S_LOG)
        begin
            // The wait exceeds 2^30 exactly when it has a bit above 30 or is 2^30 plus something.
            big_reg  <= (|lat_reg[LAT_W-1:LOG_SPAN]) ||
                        (lat_reg[LOG_SPAN-1] && (|lat_reg[LOG_SPAN-2:0]));
            zero_reg <= (lat_reg == '0);
            wm1_reg  <= lat_reg[LOG_SPAN-1:0] - 1'b1;
        end
        if (state_reg == S_ENC)
        begin
            rec_reg  <= 1'b1;
            bkt_reg  <= BW'(sat_bkt);
            bkt5_reg <= BKT_W'(sat_bkt);
        end
        if (state_reg == S_OUT && out_free)
        begin
            m_tdata_reg <= {4'b0000, cnt_reg, bkt5_reg, lat_reg};
            m_tuser_reg <= rec_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> design/rqlh_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing; used for the task table and the bucket counters.
module rqlh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/rqlh_div1000.sv
// Divider by the constant 1000: four 16-bit chunks, each split by a reciprocal
// multiplication and a remainder step. Depends on rqlh_pkg for the widths and constants.
module rqlh_div1000 (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rqlh_pkg::TIME_W-1:0] dividend,
    output logic                        done,
    output logic [rqlh_pkg::TIME_W-1:0] quotient
);
    import rqlh_pkg::*;

    localparam int CHUNKS   = TIME_W / DIV_CHUNK_W;
    localparam int CHUNK_CW = $clog2(CHUNKS);
    localparam int PART_W   = REM_W + DIV_CHUNK_W;
    localparam int PROD_W   = PART_W + DIV_RECIP_W;

    logic                   busy_reg;
    logic                   done_reg;
    logic                   phase_reg;
    logic [CHUNK_CW-1:0]    chunk_reg;
    logic [TIME_W-1:0]      num_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [DIV_CHUNK_W-1:0] q_reg;

    logic [PART_W-1:0]      part;
    logic [PROD_W-1:0]      prod;
    logic [PART_W-1:0]      qmul;
    logic [PART_W-1:0]      diff;

    // The running remainder sits above the next dividend chunk; the quotient
    // chunks shift in at the bottom while the dividend shifts out at the top.
    assign part = {rem_reg, num_reg[TIME_W-1 -: DIV_CHUNK_W]};
    assign prod = PROD_W'(part) * PROD_W'(DIV_RECIP);
    assign qmul = PART_W'(q_reg) * PART_W'(NS_PER_US);
    assign diff = part - qmul;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            chunk_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            chunk_reg <= '0;
        end
        else if (busy_reg)
        begin
            phase_reg <= ~phase_reg;
            if (phase_reg)
            begin
                chunk_reg <= chunk_reg + 1'b1;
                if (chunk_reg == CHUNK_CW'(CHUNKS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                q_reg <= prod[DIV_SHIFT +: DIV_CHUNK_W];
            end
            else
            begin
                num_reg <= {num_reg[TIME_W-DIV_CHUNK_W-1:0], q_reg};
                rem_reg <= diff[REM_W-1:0];
            end
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule
